// ----- rtl/core/box_downsample_rgb_defines.svh -----
// assertion macros for the box downsampler checker
`ifndef BOX_DOWNSAMPLE_RGB_DEFINES_SVH
`define BOX_DOWNSAMPLE_RGB_DEFINES_SVH

// implication in the same cycle, off while reset is low
`define BDR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box_downsample_rgb: same-cycle check failed");

// implication on the next cycle, off while reset is low
`define BDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box_downsample_rgb: next-cycle check failed");

// holds at every edge where reset is low
`define BDR_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge clk) (!rst_n) |-> (cons)) \
        else $error("box_downsample_rgb: reset check failed");

`endif

// ----- rtl/core/bdr_pkg.sv -----
// shared types and constants of the box downsampler
`timescale 1ns / 1ps

package bdr_pkg;

    localparam int PIX_W             = 8;
    localparam int NUM_CH            = 3;
    localparam int SCALE_W           = 4;
    localparam int OUTW_W            = 11;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 11;
    localparam int DEF_MAX_OUT_WIDTH = 1024;
    localparam int DEF_MAX_FACTOR    = 8;
    localparam int TASKQ_DEPTH       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH    = 2'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd4;
    localparam logic [OUTW_W-1:0]  OUTW_RESET  = 11'd128;

    // what the back end must do with one finished block row segment
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic row_end;
        logic frame_end;
    } task_ctrl_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } out_flags_t;

endpackage

// ----- rtl/core/box_downsample_rgb.sv -----
// top level of the integer-factor box downsampler for rgb frames
//
// channel  dir  handshake                     word
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: red, green, blue
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: red, green, blue; tlast row end; tuser frame end
// cfg      in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// one input word per clock while the four-entry task queue has room
// the back end retires one task per clock unless a last-row task waits for the divider
// after the last pixel of its block is taken, an output word passes through the queue,
// the line store read and accumulate, then nine divide stages
// a waiting output word halts the divider and accumulate stage; the queue fills, then s_axis_tready drops
// asynchronous reset clears counters, sums and pipe, config to factor 4 and width 128
// the line store is not cleared: every column is written on the first row of a band
`timescale 1ns / 1ps

module box_downsample_rgb #(
    parameter int MAX_OUT_WIDTH = bdr_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_FACTOR    = bdr_pkg::DEF_MAX_FACTOR
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [bdr_pkg::NUM_CH*bdr_pkg::PIX_W-1:0] s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic [bdr_pkg::NUM_CH*bdr_pkg::PIX_W-1:0] m_axis_tdata,
    output logic                                      m_axis_tlast,
    // frame_end [0]
    output logic                                      m_axis_tuser,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [bdr_pkg::CFG_DATA_W-1:0]            cfg_data
);

    localparam int FW     = $clog2(MAX_FACTOR + 1);
    localparam int XW     = $clog2(MAX_OUT_WIDTH);
    localparam int BLK_W  = $clog2(MAX_FACTOR * ((1 << bdr_pkg::PIX_W) - 1) + 1);
    localparam int CTRL_W = $bits(bdr_pkg::task_ctrl_t);
    localparam int SUMS_W = bdr_pkg::NUM_CH * BLK_W;
    localparam int TASK_W = CTRL_W + XW + SUMS_W;

    logic [FW-1:0]       f_eff;
    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    bdr_pkg::task_ctrl_t push_ctrl;
    logic [XW-1:0]       push_col;
    logic [SUMS_W-1:0]   push_sum;
    logic [TASK_W-1:0]   push_word;
    logic [TASK_W-1:0]   head_word;
    bdr_pkg::task_ctrl_t head_ctrl;
    logic [XW-1:0]       head_col;
    logic [SUMS_W-1:0]   head_sum;

    assign cfg_ready = 1'b1;

    bdr_front #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .MAX_FACTOR    (MAX_FACTOR)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .f_eff         (f_eff),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_ctrl        (push_ctrl),
        .q_col         (push_col),
        .q_sum         (push_sum)
    );

    assign push_word = {push_ctrl, push_col, push_sum};

    bdr_fifo #(
        .DATA_W (TASK_W),
        .DEPTH  (bdr_pkg::TASKQ_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_word),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (head_word),
        .empty (q_empty)
    );

    assign head_ctrl = head_word[TASK_W-1 -: CTRL_W];
    assign head_col  = head_word[SUMS_W +: XW];
    assign head_sum  = head_word[SUMS_W-1:0];

    bdr_back #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .MAX_FACTOR    (MAX_FACTOR)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .f_eff         (f_eff),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_ctrl        (head_ctrl),
        .q_col         (head_col),
        .q_sum         (head_sum),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/core/bdr_fifo.sv -----
// short task queue between front and back end
`timescale 1ns / 1ps

module bdr_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = bdr_pkg::TASKQ_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] dout,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/core/bdr_div.sv -----
// pipelined divide of three channel totals by the block area, saturating at full scale
`timescale 1ns / 1ps

module bdr_div #(
    parameter int SUM_W = 15,
    parameter int DIV_W = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [DIV_W-1:0]                       divisor,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [bdr_pkg::NUM_CH*SUM_W-1:0]       in_total,
    input  bdr_pkg::out_flags_t                    in_flags,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [bdr_pkg::NUM_CH*bdr_pkg::PIX_W-1:0] out_quot,
    output bdr_pkg::out_flags_t                    out_flags
);

    localparam int PIX_W  = bdr_pkg::PIX_W;
    localparam int NUM_CH = bdr_pkg::NUM_CH;
    localparam int NSTG   = PIX_W + 1;

    logic [NSTG-1:0]                   valid_reg;
    logic [NUM_CH-1:0][SUM_W-1:0]      rem_reg   [NSTG];
    logic [NUM_CH-1:0][PIX_W-1:0]      quot_reg  [NSTG];
    logic [NUM_CH-1:0]                 sat_reg   [NSTG];
    bdr_pkg::out_flags_t               flags_reg [NSTG];
    logic [SUM_W-1:0]                  dsh       [NSTG];
    logic                              adv;

    // whole pipe halts while the output word waits
    assign adv       = !valid_reg[NSTG-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg[NSTG-1];
    assign out_flags = flags_reg[NSTG-1];

    // divisor shifted for each quotient bit, stage zero tests for overflow
    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            dsh[k] = SUM_W'(divisor) << (PIX_W - k);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            out_quot[c*PIX_W +: PIX_W] = sat_reg[NSTG-1][c] ? {PIX_W{1'b1}}
                                                             : quot_reg[NSTG-1][c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_reg[0] <= in_flags;
            quot_reg[0]  <= '0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                rem_reg[0][c] <= in_total[c*SUM_W +: SUM_W];
                sat_reg[0][c] <= (in_total[c*SUM_W +: SUM_W] >= dsh[0]);
            end
            for (int k = 1; k < NSTG; k++)
            begin
                flags_reg[k] <= flags_reg[k-1];
                sat_reg[k]   <= sat_reg[k-1];
                for (int c = 0; c < NUM_CH; c++)
                begin
                    if (rem_reg[k-1][c] >= dsh[k])
                    begin
                        rem_reg[k][c]  <= rem_reg[k-1][c] - dsh[k];
                        quot_reg[k][c] <= quot_reg[k-1][c] | (PIX_W'(1) << (PIX_W - k));
                    end
                    else
                    begin
                        rem_reg[k][c]  <= rem_reg[k-1][c];
                        quot_reg[k][c] <= quot_reg[k-1][c];
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/core/bdr_front.sv -----
// front end: config registers, pixel intake, block position counters and row segment sums
`timescale 1ns / 1ps

module bdr_front #(
    parameter int MAX_OUT_WIDTH = bdr_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_FACTOR    = bdr_pkg::DEF_MAX_FACTOR,
    localparam int FW    = $clog2(MAX_FACTOR + 1),
    localparam int XW    = $clog2(MAX_OUT_WIDTH),
    localparam int BLK_W = $clog2(MAX_FACTOR * ((1 << bdr_pkg::PIX_W) - 1) + 1)
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [bdr_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [bdr_pkg::NUM_CH*bdr_pkg::PIX_W-1:0] s_axis_tdata,
    output logic [FW-1:0]                            f_eff,
    input  logic                                     q_full,
    output logic                                     q_push,
    output bdr_pkg::task_ctrl_t                      q_ctrl,
    output logic [XW-1:0]                            q_col,
    output logic [bdr_pkg::NUM_CH*BLK_W-1:0]         q_sum
);

    localparam int PIX_W  = bdr_pkg::PIX_W;
    localparam int NUM_CH = bdr_pkg::NUM_CH;
    localparam int WW     = $clog2(MAX_OUT_WIDTH + 1);
    localparam int SCW    = (FW > bdr_pkg::SCALE_W) ? FW : bdr_pkg::SCALE_W;
    localparam int OWW    = (WW > bdr_pkg::OUTW_W) ? WW : bdr_pkg::OUTW_W;

    logic [bdr_pkg::SCALE_W-1:0]  scale_factor_reg;
    logic [bdr_pkg::OUTW_W-1:0]   out_width_reg;
    logic [FW-1:0]                sub_x_reg;
    logic [FW-1:0]                sub_x_next;
    logic [FW-1:0]                sub_y_reg;
    logic [FW-1:0]                sub_y_next;
    logic [XW-1:0]                out_x_reg;
    logic [XW-1:0]                out_x_next;
    logic [XW-1:0]                out_y_reg;
    logic [XW-1:0]                out_y_next;
    logic [NUM_CH-1:0][BLK_W-1:0] block_sum_reg;
    logic [NUM_CH-1:0][BLK_W-1:0] block_sum_next;
    logic [NUM_CH-1:0][BLK_W-1:0] seg_sum;
    logic [SCW-1:0]               sc_ext;
    logic [OWW-1:0]               ow_ext;
    logic [WW-1:0]                w_eff;
    logic [FW-1:0]                sx1;
    logic [FW-1:0]                sy1;
    logic [WW-1:0]                xx1;
    logic [WW-1:0]                yy1;
    logic                         accept;
    logic                         block_end;
    logic                         band_last;
    logic                         row_last;
    logic                         col_last;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    // out-of-range register values are clamped into the legal range
    always_comb
    begin
        sc_ext = SCW'(scale_factor_reg);
        ow_ext = OWW'(out_width_reg);
        if (sc_ext == '0)
        begin
            f_eff = FW'(1);
        end
        else if (sc_ext > SCW'(MAX_FACTOR))
        begin
            f_eff = FW'(MAX_FACTOR);
        end
        else
        begin
            f_eff = FW'(sc_ext);
        end
        if (ow_ext == '0)
        begin
            w_eff = WW'(1);
        end
        else if (ow_ext > OWW'(MAX_OUT_WIDTH))
        begin
            w_eff = WW'(MAX_OUT_WIDTH);
        end
        else
        begin
            w_eff = WW'(ow_ext);
        end
    end

    // end tests are counter + 1 >= limit so a shrunk limit still closes things off
    assign sx1       = sub_x_reg + 1'b1;
    assign sy1       = sub_y_reg + 1'b1;
    assign xx1       = WW'(out_x_reg) + 1'b1;
    assign yy1       = WW'(out_y_reg) + 1'b1;
    assign block_end = (sx1 >= f_eff);
    assign band_last = (sy1 >= f_eff);
    assign row_last  = (xx1 >= w_eff);
    assign col_last  = (yy1 >= w_eff);

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            seg_sum[c] = block_sum_reg[c] + BLK_W'(s_axis_tdata[c*PIX_W +: PIX_W]);
        end
    end

    always_comb
    begin
        sub_x_next     = sub_x_reg;
        sub_y_next     = sub_y_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        block_sum_next = block_sum_reg;
        if (accept)
        begin
            if (!block_end)
            begin
                sub_x_next     = sx1;
                block_sum_next = seg_sum;
            end
            else
            begin
                sub_x_next     = '0;
                block_sum_next = '0;
                if (row_last)
                begin
                    out_x_next = '0;
                    if (band_last)
                    begin
                        sub_y_next = '0;
                        out_y_next = col_last ? '0 : XW'(yy1);
                    end
                    else
                    begin
                        sub_y_next = sy1;
                    end
                end
                else
                begin
                    out_x_next = XW'(xx1);
                end
            end
        end
    end

    assign q_push           = accept && block_end;
    assign q_ctrl.first_row = (sub_y_reg == '0);
    assign q_ctrl.last_row  = band_last;
    assign q_ctrl.row_end   = row_last;
    assign q_ctrl.frame_end = row_last && col_last;
    assign q_col            = out_x_reg;
    assign q_sum            = seg_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg <= bdr_pkg::SCALE_RESET;
            out_width_reg    <= bdr_pkg::OUTW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bdr_pkg::CFG_SCALE_FACTOR:
                begin
                    scale_factor_reg <= cfg_data[bdr_pkg::SCALE_W-1:0];
                end
                bdr_pkg::CFG_OUT_WIDTH:
                begin
                    out_width_reg <= cfg_data[bdr_pkg::OUTW_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_x_reg     <= '0;
            sub_y_reg     <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            block_sum_reg <= '0;
        end
        else
        begin
            sub_x_reg     <= sub_x_next;
            sub_y_reg     <= sub_y_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            block_sum_reg <= block_sum_next;
        end
    end

endmodule

// ----- rtl/core/bdr_back.sv -----
// back end: column sum line store, band accumulation and hand-off to the divider
`timescale 1ns / 1ps

module bdr_back #(
    parameter int MAX_OUT_WIDTH = bdr_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_FACTOR    = bdr_pkg::DEF_MAX_FACTOR,
    localparam int FW    = $clog2(MAX_FACTOR + 1),
    localparam int XW    = $clog2(MAX_OUT_WIDTH),
    localparam int BLK_W = $clog2(MAX_FACTOR * ((1 << bdr_pkg::PIX_W) - 1) + 1)
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [FW-1:0]                             f_eff,
    input  logic                                      q_empty,
    output logic                                      q_pop,
    input  bdr_pkg::task_ctrl_t                       q_ctrl,
    input  logic [XW-1:0]                             q_col,
    input  logic [bdr_pkg::NUM_CH*BLK_W-1:0]          q_sum,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [bdr_pkg::NUM_CH*bdr_pkg::PIX_W-1:0] m_axis_tdata,
    output logic                                      m_axis_tlast,
    output logic                                      m_axis_tuser
);

    localparam int NUM_CH = bdr_pkg::NUM_CH;
    // wide enough that a saturated sum still divides to full scale
    localparam int SUM_W  = $clog2((1 << bdr_pkg::PIX_W) * MAX_FACTOR * MAX_FACTOR) + 1;
    localparam int DIV_W  = 2 * FW;

    logic [NUM_CH*SUM_W-1:0]      mem [MAX_OUT_WIDTH];
    logic [NUM_CH*SUM_W-1:0]      rd_mem_reg;
    logic [NUM_CH*SUM_W-1:0]      fwd_data_reg;
    logic                         fwd_reg;
    logic                         exec_valid_reg;
    bdr_pkg::task_ctrl_t          exec_ctrl_reg;
    logic [XW-1:0]                exec_col_reg;
    logic [NUM_CH-1:0][BLK_W-1:0] exec_blk_reg;
    logic [NUM_CH*SUM_W-1:0]      col_val;
    logic [NUM_CH*SUM_W-1:0]      total;
    logic [SUM_W:0]               ext_sum [NUM_CH];
    logic [DIV_W-1:0]             divisor;
    logic                         exec_done;
    logic                         wr_en;
    logic                         fwd;
    logic                         div_in_valid;
    logic                         div_in_ready;
    bdr_pkg::out_flags_t          div_in_flags;
    bdr_pkg::out_flags_t          div_out_flags;

    assign divisor   = DIV_W'(f_eff) * DIV_W'(f_eff);
    assign exec_done = !exec_ctrl_reg.last_row || div_in_ready;
    assign q_pop     = !q_empty && (!exec_valid_reg || exec_done);
    assign wr_en     = exec_valid_reg && !exec_ctrl_reg.last_row;
    // a read of the column being written this cycle takes the new sum
    assign fwd       = wr_en && (exec_col_reg == q_col);
    assign col_val   = fwd_reg ? fwd_data_reg : rd_mem_reg;

    // saturating add keeps stale oversized sums from wrapping
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            ext_sum[c] = (SUM_W + 1)'(exec_blk_reg[c]);
            if (!exec_ctrl_reg.first_row)
            begin
                ext_sum[c] = ext_sum[c] + (SUM_W + 1)'(col_val[c*SUM_W +: SUM_W]);
            end
            total[c*SUM_W +: SUM_W] = ext_sum[c][SUM_W] ? {SUM_W{1'b1}}
                                                        : ext_sum[c][SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[exec_col_reg] <= total;
        end
        if (q_pop)
        begin
            rd_mem_reg   <= mem[q_col];
            fwd_reg      <= fwd;
            fwd_data_reg <= total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
            exec_ctrl_reg  <= '0;
        end
        else if (q_pop)
        begin
            exec_valid_reg <= 1'b1;
            exec_ctrl_reg  <= q_ctrl;
        end
        else if (exec_done)
        begin
            exec_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            exec_col_reg <= q_col;
            exec_blk_reg <= q_sum;
        end
    end

    assign div_in_valid           = exec_valid_reg && exec_ctrl_reg.last_row;
    assign div_in_flags.row_end   = exec_ctrl_reg.row_end;
    assign div_in_flags.frame_end = exec_ctrl_reg.frame_end;

    bdr_div #(
        .SUM_W (SUM_W),
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .divisor   (divisor),
        .in_valid  (div_in_valid),
        .in_ready  (div_in_ready),
        .in_total  (total),
        .in_flags  (div_in_flags),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_quot  (m_axis_tdata),
        .out_flags (div_out_flags)
    );

    assign m_axis_tlast = div_out_flags.row_end;
    assign m_axis_tuser = div_out_flags.frame_end;

endmodule

// ----- rtl/core/bdr_checker.sv -----
// port-level checks on the box downsampler, bound to the top level
`timescale 1ns / 1ps
`include "box_downsample_rgb_defines.svh"

module bdr_checker (
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      m_axis_tvalid,
    input logic                                      m_axis_tready,
    input logic [bdr_pkg::NUM_CH*bdr_pkg::PIX_W-1:0] m_axis_tdata,
    input logic                                      m_axis_tlast,
    input logic                                      m_axis_tuser
);

    // the last pixel of the frame also closes its row
    `BDR_ASSERT_IMPL(a_frame_end_closes_row, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

    // a stalled output word holds
    `BDR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // reset empties the output pipe
    `BDR_ASSERT_RESET(a_reset_no_out, !m_axis_tvalid)

endmodule

bind box_downsample_rgb bdr_checker u_bdr_checker (.*);

// ----- tb/tb_box_downsample_rgb.sv -----
// self-checking stream testbench for the rgb box downsampler
`timescale 1ns / 1ps

module tb_box_downsample_rgb;

    localparam int PIX_W        = bdr_pkg::PIX_W;
    localparam int NUM_CH       = bdr_pkg::NUM_CH;
    localparam int CFG_IDX_W    = bdr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = bdr_pkg::CFG_DATA_W;
    localparam int SCALE_W      = bdr_pkg::SCALE_W;
    localparam int OUTW_W       = bdr_pkg::OUTW_W;
    localparam int CLK_PERIOD   = 12;
    localparam int MAX_W        = bdr_pkg::DEF_MAX_OUT_WIDTH;
    localparam int MAX_F        = bdr_pkg::DEF_MAX_FACTOR;
    localparam int RANDOM_ITEMS = 380;
    localparam int FRAME_CAP    = 64;
    localparam int WIDE_ITEMS   = 48;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SHOW_ERRORS  = 20;

    // an index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             row_end;
        logic             frame_end;
    } avg_pixel_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [NUM_CH*PIX_W-1:0] s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [NUM_CH*PIX_W-1:0] m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    m_axis_tuser;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;

    // shadow of the block: registers, line store, sums and position
    logic [SCALE_W-1:0] scale_reg = bdr_pkg::SCALE_RESET;
    logic [OUTW_W-1:0]  width_reg = bdr_pkg::OUTW_RESET;
    int unsigned        col_sum [NUM_CH][MAX_W];
    bit                 col_written [MAX_W];
    int unsigned        blk_sum [NUM_CH];
    int                 sub_x = 0;
    int                 sub_y = 0;
    int                 out_x = 0;
    int                 out_y = 0;

    rgb_t       pixel_q [$];
    avg_pixel_t expected_avgs [$];

    bit       in_flight  = 1'b0;
    bit       bursty     = 1'b1;
    int       burst_left = 1;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    logic [7:0] rx_pattern = 8'hff;
    int       rx_tick    = 0;
    bit       hold_req   = 1'b0;
    int       hold_left  = 0;

    int cycles      = 0;
    int n_errors    = 0;
    int n_pixels    = 0;
    int n_results   = 0;
    int n_frames    = 0;
    int n_cfg       = 0;
    int n_holds     = 0;
    int n_saturated = 0;

    box_downsample_rgb u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int eff_factor(input logic [SCALE_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_F)
            return MAX_F;
        return int'(raw);
    endfunction

    function automatic int eff_width(input logic [OUTW_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_W)
            return MAX_W;
        return int'(raw);
    endfunction

    // moves the in-block and output position on by one input pixel
    function automatic void advance_position(input int f, input int w,
                                             inout int sx, inout int sy,
                                             inout int ox, inout int oy,
                                             output bit blk_done, output bit emit,
                                             output bit row_last, output bit frame_last);
        blk_done   = (sx + 1 >= f);
        emit       = blk_done && (sy + 1 >= f);
        row_last   = (ox + 1 >= w);
        frame_last = row_last && (oy + 1 >= w);
        if (!blk_done)
        begin
            sx++;
            return;
        end
        sx = 0;
        if (row_last)
        begin
            ox = 0;
            if (sy + 1 >= f)
            begin
                sy = 0;
                oy = (oy + 1 >= w) ? 0 : oy + 1;
            end
            else
            begin
                sy++;
            end
        end
        else
        begin
            ox++;
        end
    endfunction

    // box average of one pixel; returns 1 when an output word is due
    function automatic bit predict_average(input rgb_t px, output avg_pixel_t avg);
        int          f;
        int          w;
        int          col;
        int          sy;
        int          c;
        bit          done;
        bit          emit;
        bit          rl;
        bit          fl;
        int unsigned total;
        int unsigned q;
        int unsigned chan [NUM_CH];
        f       = eff_factor(scale_reg);
        w       = eff_width(width_reg);
        col     = (out_x >= MAX_W) ? MAX_W - 1 : out_x;
        sy      = sub_y;
        avg     = '0;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        for (c = 0; c < NUM_CH; c++)
            blk_sum[c] += chan[c];
        advance_position(f, w, sub_x, sub_y, out_x, out_y, done, emit, rl, fl);
        if (!done)
            return 1'b0;
        for (c = 0; c < NUM_CH; c++)
        begin
            total = blk_sum[c] + ((sy != 0) ? col_sum[c][col] : 0);
            if (emit)
            begin
                q = total / (f * f);
                if (q > 255)
                begin
                    q = 255;
                    n_saturated++;
                end
                chan[c] = q;
            end
            else
            begin
                col_sum[c][col] = total;
            end
            blk_sum[c] = 0;
        end
        if (!emit)
        begin
            col_written[col] = 1'b1;
            return 1'b0;
        end
        avg.red       = PIX_W'(chan[0]);
        avg.green     = PIX_W'(chan[1]);
        avg.blue      = PIX_W'(chan[2]);
        avg.row_end   = rl;
        avg.frame_end = fl;
        return 1'b1;
    endfunction

    // a new setting must never make the block read a column it has not written
    function automatic bit store_ready_for(input int f, input int w);
        int span;
        int c;
        if (sub_y == 0 && (f == 1 || out_x == 0))
            return 1'b1;
        span = (w > out_x + 1) ? w : out_x + 1;
        for (c = 0; c < span; c++)
            if (!col_written[c])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int pixels_to_frame_end();
        int sx;
        int sy;
        int ox;
        int oy;
        int f;
        int w;
        int n;
        bit done;
        bit emit;
        bit rl;
        bit fl;
        sx   = sub_x;
        sy   = sub_y;
        ox   = out_x;
        oy   = out_y;
        f    = eff_factor(scale_reg);
        w    = eff_width(width_reg);
        n    = 0;
        emit = 1'b0;
        fl   = 1'b0;
        while (!(emit && fl))
        begin
            advance_position(f, w, sx, sy, ox, oy, done, emit, rl, fl);
            n++;
        end
        return n;
    endfunction

    function automatic logic [PIX_W-1:0] rand_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic rgb_t rgb(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                 input logic [PIX_W-1:0] b);
        rgb_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= SHOW_ERRORS)
            $display("mismatch at output word %0d: %s got %0h expected %0h",
                     n_results, what, got, want);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == bdr_pkg::CFG_SCALE_FACTOR)
            scale_reg = val[SCALE_W-1:0];
        else if (idx == bdr_pkg::CFG_OUT_WIDTH)
            width_reg = val[OUTW_W-1:0];
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(input rgb_t px);
        pixel_q.insert(pixel_q.size(), px);
    endtask

    task automatic feed_random(input int n);
        repeat (n)
            queue_pixel(rgb(rand_level(), rand_level(), rand_level()));
    endtask

    // pixels without a result may still sit in the pipe once the last word is out
    task automatic wait_drained();
        while (pixel_q.size() != 0 || expected_avgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : accept_pixels
        avg_pixel_t avg;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (predict_average(rgb_t'(s_axis_tdata), avg))
                expected_avgs.insert(expected_avgs.size(), avg);
            void'(pixel_q.pop_front());
            n_pixels++;
        end
        in_flight = s_axis_tvalid && !s_axis_tready;
    end

    always @(negedge clk)
    begin : drive_pixels
        if (!in_flight)
        begin
            if (pixel_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left--;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_q[0];
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = bursty ? $urandom_range(1, 6) : 0;
                end
                else
                begin
                    burst_left--;
                end
            end
        end
    end

    always @(negedge clk)
    begin : drive_ready
        rx_tick++;
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
            n_holds++;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            case (rx_mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 9) < 6);
                default:    m_axis_tready <= rx_pattern[rx_tick % 8];
            endcase
        end
    end

    always @(posedge clk)
    begin : check_averages
        avg_pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (m_axis_tuser)
                n_frames++;
            if (expected_avgs.size() == 0)
            begin
                report_mismatch("word with nothing expected, tdata", 32'(m_axis_tdata), 0);
            end
            else
            begin
                want = expected_avgs.pop_front();
                if (m_axis_tdata[PIX_W-1:0] !== want.red)
                    report_mismatch("red", 32'(m_axis_tdata[PIX_W-1:0]), 32'(want.red));
                if (m_axis_tdata[2*PIX_W-1:PIX_W] !== want.green)
                    report_mismatch("green", 32'(m_axis_tdata[2*PIX_W-1:PIX_W]),
                                    32'(want.green));
                if (m_axis_tdata[3*PIX_W-1:2*PIX_W] !== want.blue)
                    report_mismatch("blue", 32'(m_axis_tdata[3*PIX_W-1:2*PIX_W]),
                                    32'(want.blue));
                if (m_axis_tlast !== want.row_end)
                    report_mismatch("row end", 32'(m_axis_tlast), 32'(want.row_end));
                if (m_axis_tuser !== want.frame_end)
                    report_mismatch("frame end", 32'(m_axis_tuser), 32'(want.frame_end));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, expected_avgs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        int f_raw;
        int w_raw;
        int f;
        int w;
        int n;
        int phase;
        int n_random;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // factor 1 passes a 3 by 3 frame through, channel extremes and bit patterns
        cfg_write(bdr_pkg::CFG_SCALE_FACTOR, CFG_DATA_W'(1));
        cfg_write(bdr_pkg::CFG_OUT_WIDTH, CFG_DATA_W'(3));
        queue_pixel(rgb(8'h00, 8'h00, 8'h00));
        queue_pixel(rgb(8'hff, 8'hff, 8'hff));
        queue_pixel(rgb(8'hff, 8'h00, 8'h00));
        queue_pixel(rgb(8'h00, 8'hff, 8'h00));
        queue_pixel(rgb(8'h00, 8'h00, 8'hff));
        queue_pixel(rgb(8'haa, 8'h55, 8'h0f));
        queue_pixel(rgb(8'h55, 8'haa, 8'hf0));
        queue_pixel(rgb(8'h01, 8'h80, 8'hfe));
        queue_pixel(rgb(8'h7f, 8'h02, 8'hfd));
        wait_drained();

        // spare index must leave both registers alone; zero factor and width act as 1
        cfg_write(CFG_SPARE, '1);
        cfg_write(bdr_pkg::CFG_SCALE_FACTOR, CFG_DATA_W'(0));
        cfg_write(bdr_pkg::CFG_OUT_WIDTH, CFG_DATA_W'(0));
        queue_pixel(rgb(8'hff, 8'h00, 8'h80));
        wait_drained();

        // upper data bits of the factor write are dropped: factor 2, one 2x2 block
        cfg_write(bdr_pkg::CFG_SCALE_FACTOR, 11'h7f2);
        cfg_write(bdr_pkg::CFG_OUT_WIDTH, CFG_DATA_W'(1));
        queue_pixel(rgb(8'hff, 8'hff, 8'hff));
        queue_pixel(rgb(8'hff, 8'hff, 8'hff));
        queue_pixel(rgb(8'hff, 8'hff, 8'hff));
        queue_pixel(rgb(8'hfc, 8'h03, 8'h80));
        // half a band, then factor 1: the stored row sum overflows and saturates
        queue_pixel(rgb(8'hff, 8'hff, 8'hff));
        queue_pixel(rgb(8'hfa, 8'hc8, 8'hff));
        wait_drained();
        cfg_write(bdr_pkg::CFG_SCALE_FACTOR, CFG_DATA_W'(1));
        queue_pixel(rgb(8'hff, 8'hff, 8'h10));
        wait_drained();
        // sub-column counter already past a smaller factor
        cfg_write(bdr_pkg::CFG_SCALE_FACTOR, CFG_DATA_W'(4));
        feed_random(3);
        wait_drained();
        cfg_write(bdr_pkg::CFG_SCALE_FACTOR, CFG_DATA_W'(2));
        feed_random(3);

        phase    = 0;
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    f_raw = MAX_F;
                    w_raw = 1;
                end
                1:
                begin
                    f_raw = 15;
                    w_raw = 1;
                end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       f_raw = 0;
                        1:       f_raw = $urandom_range(MAX_F + 1, 15);
                        default: f_raw = $urandom_range(1, MAX_F);
                    endcase
                    case ($urandom_range(0, 14))
                        0:       w_raw = 0;
                        1:
                        begin
                            // wide rows only at factor 1 so a band never spans them
                            w_raw = $urandom_range(MAX_W, 2047);
                            f_raw = $urandom_range(0, 1);
                        end
                        default: w_raw = $urandom_range(1, (12 / eff_factor(f_raw)) + 1);
                    endcase
                end
            endcase
            if (!store_ready_for(eff_factor(f_raw), eff_width(w_raw)))
            begin
                if (sub_y == 0)
                begin
                    f_raw = 1;
                end
                else
                begin
                    f_raw = scale_reg;
                    w_raw = width_reg;
                end
            end
            if ($urandom_range(0, 1) == 0)
            begin
                cfg_write(bdr_pkg::CFG_SCALE_FACTOR,
                          CFG_DATA_W'(f_raw) | CFG_DATA_W'($urandom_range(0, 127) << SCALE_W));
                cfg_write(bdr_pkg::CFG_OUT_WIDTH, CFG_DATA_W'(w_raw));
            end
            else
            begin
                cfg_write(bdr_pkg::CFG_OUT_WIDTH, CFG_DATA_W'(w_raw));
                cfg_write(bdr_pkg::CFG_SCALE_FACTOR,
                          CFG_DATA_W'(f_raw) | CFG_DATA_W'($urandom_range(0, 127) << SCALE_W));
            end
            bursty     = ($urandom_range(0, 3) != 0);
            rx_mode    = rx_mode_t'($urandom_range(0, 2));
            rx_pattern = 8'($urandom) | 8'h01;
            f = eff_factor(scale_reg);
            w = eff_width(width_reg);
            n = 0;
            if (f * w <= 16 && $urandom_range(0, 3) != 0)
                n = pixels_to_frame_end();
            if (n == 0 || n > FRAME_CAP)
                n = $urandom_range(1, 40);
            if (phase == 2 || $urandom_range(0, 9) == 0)
            begin
                bursty   = 1'b0;
                hold_req = 1'b1;
            end
            feed_random(n);
            n_random += n;
            phase++;
        end
        wait_drained();

        // finish the frame first if a band is open, then factor 1 so no column is read
        if (sub_y != 0)
        begin
            feed_random(pixels_to_frame_end());
            wait_drained();
        end
        cfg_write(bdr_pkg::CFG_SCALE_FACTOR, CFG_DATA_W'(1));
        // width above the maximum clamps to it; a long hold-off fills the block
        cfg_write(bdr_pkg::CFG_OUT_WIDTH, CFG_DATA_W'(2047));
        bursty   = 1'b0;
        rx_mode  = RX_RANDOM;
        hold_req = 1'b1;
        feed_random(WIDE_ITEMS);
        wait_drained();
        // column counter far past a width of 1 ends row and frame at once
        bursty  = 1'b1;
        rx_mode = RX_PATTERN;
        cfg_write(bdr_pkg::CFG_OUT_WIDTH, CFG_DATA_W'(1));
        feed_random(2);
        wait_drained();

        $display("run covered %0d input pixels, %0d output words, %0d frame ends, %0d writes",
                 n_pixels, n_results, n_frames, n_cfg);
        $display("%0d long receiver hold-offs, %0d saturated channel averages, %0d mismatches",
                 n_holds, n_saturated, n_errors);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
